### rtl/uer_pkg.sv
package uer_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int COUNT_W    = 32;
  localparam int OFFSET_W   = 8;
  localparam int DIST_W     = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 2'd2;

  localparam logic [COUNT_W-1:0]  TRIGGER_ON_RESET  = 32'd3;
  localparam logic [COUNT_W-1:0]  TRIGGER_OFF_RESET = 32'd9;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET      = 8'd8;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // distance = floor(elapsed * 5 / 292); at or beyond SAT_ELAPSED the result always saturates
  localparam logic [COUNT_W-1:0] SAT_ELAPSED = 32'd3842195;
  localparam int ELAP_W      = 22;
  localparam int Y_W         = 25;
  localparam int RECIP_W     = 26;
  localparam int PROD_W      = Y_W + RECIP_W;
  localparam int RECIP_SHIFT = 34;
  localparam int Q_W         = 17;
  localparam logic [RECIP_W-1:0] RECIP = 26'd58835169;

  typedef struct packed {
    logic valid;
    logic pop;
    logic push;
    logic trigger;
  } ctl_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

endpackage

### rtl/uer_if.sv
interface uer_item_if;
  logic valid;
  logic ready;
  logic cmd;
  logic echo_level;

  modport source (output valid, output cmd, output echo_level, input ready);
  modport sink (input valid, input cmd, input echo_level, output ready);
endinterface

interface uer_result_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger_level;
  logic                       measured;
  logic [uer_pkg::DIST_W-1:0] distance_cm;
  logic                       pop_valid;
  logic [uer_pkg::DIST_W-1:0] pop_data;

  modport source (output valid, output trigger_level, output measured, output distance_cm,
                  output pop_valid, output pop_data, input ready);
  modport sink (input valid, input trigger_level, input measured, input distance_cm,
                input pop_valid, input pop_data, output ready);
endinterface

### rtl/uer_convert.sv
module uer_convert (
  input  logic                         clk,
  input  logic                         advance,
  input  logic [uer_pkg::COUNT_W-1:0]  count,
  input  logic [uer_pkg::COUNT_W-1:0]  on_count,
  input  logic [uer_pkg::OFFSET_W-1:0] offset,
  output logic [uer_pkg::DIST_W-1:0]   dist_cm
);

  logic [uer_pkg::COUNT_W-1:0] elapsed;
  logic [uer_pkg::ELAP_W-1:0]  e_low;
  logic [uer_pkg::Y_W-1:0]     y_next;
  logic [uer_pkg::Y_W-1:0]     y;
  logic                        sat1;
  logic [uer_pkg::PROD_W-1:0]  prod;
  logic [uer_pkg::Q_W-1:0]     q;
  logic                        sat2;
  logic [uer_pkg::Q_W-1:0]     diff;

  always_comb begin
    elapsed = (count > on_count) ? count - on_count - 32'd1 : '0;
    e_low   = elapsed[uer_pkg::ELAP_W-1:0];
    y_next  = {1'b0, e_low, 2'b00} + {3'b000, e_low};
    prod    = uer_pkg::PROD_W'(y) * uer_pkg::PROD_W'(uer_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      y    <= y_next;
      sat1 <= (elapsed >= uer_pkg::SAT_ELAPSED);
      q    <= prod[uer_pkg::RECIP_SHIFT +: uer_pkg::Q_W];
      sat2 <= sat1;
    end
  end

  always_comb begin
    diff = q - uer_pkg::Q_W'(offset);
    if (sat2) begin
      dist_cm = '1;
    end else if (q <= uer_pkg::Q_W'(offset)) begin
      dist_cm = '0;
    end else if (diff[uer_pkg::Q_W-1]) begin
      dist_cm = '1;
    end else begin
      dist_cm = diff[uer_pkg::DIST_W-1:0];
    end
  end

endmodule

### rtl/ultrasonic_echo_ranger_fifo.sv
// Pipeline: an item is registered at its transfer edge (echo capture, multiply by 5), then
// in the reciprocal multiply stage, and last at FIFO access in the output register, from
// which its result is offered.
// Throughput: one item per cycle; a waiting result holds the whole pipeline and the input.
// Reset (rst, synchronous): counter, trigger, echo history, pipeline valids, FIFO pointers and fill
// count clear; configuration returns to on 3, off 9, offset 8. FIFO contents persist.
module ultrasonic_echo_ranger_fifo (
  input  logic                           clk,
  input  logic                           rst,
  uer_item_if.sink                       item,
  uer_result_if.source                   result,
  input  logic                           cfg_wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [uer_pkg::COUNT_W-1:0]  trigger_on_count;
  logic [uer_pkg::COUNT_W-1:0]  trigger_off_count;
  logic [uer_pkg::OFFSET_W-1:0] distance_offset;

  logic [uer_pkg::COUNT_W-1:0] tick_count;
  logic                        trigger_reg;
  logic                        echo_prev;
  logic                        trig_next;
  logic                        is_tick;
  logic                        echo_fall;
  logic                        advance;
  logic                        accept;

  uer_pkg::ctl_t s1;
  uer_pkg::ctl_t s2;
  logic [uer_pkg::DIST_W-1:0] dist_cm;

  logic [uer_pkg::DIST_W-1:0] mem [uer_pkg::FIFO_DEPTH];
  logic [uer_pkg::DIST_W-1:0] rd_data;
  logic [uer_pkg::PTR_W-1:0]  wr_ptr;
  logic [uer_pkg::PTR_W-1:0]  rd_ptr;
  logic [uer_pkg::CNT_W-1:0]  count;
  logic                       fifo_full;
  logic                       fifo_empty;
  logic [uer_pkg::CNT_W:0]    ptr_sum;

  logic                       out_vld;
  logic                       out_trigger;
  logic                       out_measured;
  logic [uer_pkg::DIST_W-1:0] out_dist;
  logic                       out_pop_valid;

  assign advance    = !out_vld || result.ready;
  assign accept     = item.valid && advance;
  assign item.ready = advance;
  assign is_tick    = (item.cmd == uer_pkg::CMD_TICK);
  assign echo_fall  = echo_prev && !item.echo_level;
  assign fifo_full  = (count == uer_pkg::CNT_W'(uer_pkg::FIFO_DEPTH));
  assign fifo_empty = (count == '0);
  assign ptr_sum    = (uer_pkg::CNT_W + 1)'(rd_ptr) + (uer_pkg::CNT_W + 1)'(count);

  always_comb begin
    trig_next = trigger_reg;
    if (tick_count == trigger_on_count) begin
      trig_next = 1'b1;
    end
    if (tick_count == trigger_off_count) begin
      trig_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_on_count  <= uer_pkg::TRIGGER_ON_RESET;
      trigger_off_count <= uer_pkg::TRIGGER_OFF_RESET;
      distance_offset   <= uer_pkg::OFFSET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        uer_pkg::CFG_TRIGGER_ON:  trigger_on_count  <= cfg_data;
        uer_pkg::CFG_TRIGGER_OFF: trigger_off_count <= cfg_data;
        uer_pkg::CFG_OFFSET:      distance_offset   <= cfg_data[uer_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      trigger_reg <= 1'b0;
      echo_prev   <= 1'b0;
      s1          <= '0;
      s2          <= '0;
    end else begin
      if (accept && is_tick) begin
        trigger_reg <= trig_next;
        echo_prev   <= item.echo_level;
        tick_count  <= echo_fall ? '0 : tick_count + 32'd1;
      end
      if (advance) begin
        s1.valid   <= item.valid;
        s1.pop     <= !is_tick;
        s1.push    <= is_tick && echo_fall;
        s1.trigger <= is_tick ? trig_next : trigger_reg;
        s2         <= s1;
      end
    end
  end

  uer_convert u_convert (
    .clk      (clk),
    .advance  (advance),
    .count    (tick_count),
    .on_count (trigger_on_count),
    .offset   (distance_offset),
    .dist_cm  (dist_cm)
  );

  always_ff @(posedge clk) begin
    if (advance && s2.valid && s2.push) begin
      mem[wr_ptr] <= dist_cm;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (advance && s2.valid) begin
      if (s2.push) begin
        wr_ptr <= uer_pkg::next_slot(wr_ptr);
        if (fifo_full) begin
          rd_ptr <= uer_pkg::next_slot(rd_ptr);
        end else begin
          count <= count + 1'b1;
        end
      end else if (s2.pop && !fifo_empty) begin
        rd_ptr <= uer_pkg::next_slot(rd_ptr);
        count  <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_trigger   <= s2.trigger;
      out_measured  <= s2.push;
      out_dist      <= s2.push ? dist_cm : '0;
      out_pop_valid <= s2.pop && !fifo_empty;
    end
  end

  assign result.valid         = out_vld;
  assign result.trigger_level = out_trigger;
  assign result.measured      = out_measured;
  assign result.distance_cm   = out_dist;
  assign result.pop_valid     = out_pop_valid;
  assign result.pop_data      = out_pop_valid ? rd_data : '0;

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_vld)
    else $error("result valid after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= uer_pkg::CNT_W'(uer_pkg::FIFO_DEPTH))
    else $error("fill count beyond depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    (ptr_sum == (uer_pkg::CNT_W + 1)'(wr_ptr)) ||
    (ptr_sum == (uer_pkg::CNT_W + 1)'(wr_ptr) + (uer_pkg::CNT_W + 1)'(uer_pkg::FIFO_DEPTH)))
    else $error("read pointer, fill count and write pointer disagree");

  a_push_full_stays_full: assert property (@(posedge clk) disable iff (rst)
    (advance && s2.valid && s2.push && fifo_full) |=> fifo_full)
    else $error("overwrite on full FIFO changed fill count");

  a_pop_excl_measure: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_measured && out_pop_valid))
    else $error("result both measured and popped");

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int LONG_ECHO   = 150;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    logic              trigger_level;
    logic              measured;
    logic [DIST_W-1:0] distance_cm;
    logic              pop_valid;
    logic [DIST_W-1:0] pop_data;
  } ranger_result_t;

  typedef struct packed {
    logic           cmd;
    logic           echo;
    logic [19:0]    reps;
    logic           typed;
    ranger_result_t want;
  } dir_row_t;

  // reset settings: trigger high at count 3, low at 9, offset 8
  localparam dir_row_t DIR_ROWS [12] = '{
    '{CMD_POP,  1'b0, 20'd1, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0, 16'd0}},
    '{CMD_TICK, 1'b0, 20'd3, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0, 16'd0}},
    '{CMD_TICK, 1'b1, 20'd1, 1'b1, '{1'b1, 1'b0, 16'd0, 1'b0, 16'd0}},
    '{CMD_TICK, 1'b0, 20'd1, 1'b1, '{1'b1, 1'b1, 16'd0, 1'b0, 16'd0}},
    '{CMD_POP,  1'b1, 20'd1, 1'b1, '{1'b1, 1'b0, 16'd0, 1'b1, 16'd0}},
    '{CMD_POP,  1'b0, 20'd1, 1'b1, '{1'b1, 1'b0, 16'd0, 1'b0, 16'd0}},
    '{CMD_TICK, 1'b1, 20'd1, 1'b0, '0},
    '{CMD_TICK, 1'b0, 20'd1, 1'b1, '{1'b1, 1'b1, 16'd0, 1'b0, 16'd0}},
    '{CMD_TICK, 1'b0, 20'd9, 1'b0, '0},
    '{CMD_TICK, 1'b1, 20'd1, 1'b0, '0},
    '{CMD_TICK, 1'b0, 20'd1, 1'b0, '0},
    '{CMD_POP,  1'b0, 20'd1, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  uer_item_if   item_ch ();
  uer_result_if result_ch ();

  ultrasonic_echo_ranger_fifo i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and its copy of the registers
  logic [COUNT_W-1:0]  m_on;
  logic [COUNT_W-1:0]  m_off;
  logic [OFFSET_W-1:0] m_offset;
  logic [COUNT_W-1:0]  m_ticks;
  logic                m_trig;
  logic                m_echo_q;
  logic [DIST_W-1:0]   m_dist_mem [FIFO_DEPTH];
  int                  m_wr_ptr;
  int                  m_rd_ptr;
  int                  m_fill;

  ranger_result_t ranger_results_q [$];
  ranger_result_t result_seen;

  int n_errors;
  int items_sent;
  int n_meas;
  int n_pops;
  int n_empty_pops;
  int n_overwrites;
  int n_settings;
  int burst_left;
  bit gaps_on;
  bit hold_req;
  int hold_left;
  int stall_pattern;
  int stall_stretch;
  int stall_phase;
  int idle_cycles;

  function automatic logic [DIST_W-1:0] echo_to_cm(input logic [COUNT_W-1:0] c);
    logic [63:0] elapsed;
    logic [63:0] d;
    if (c <= m_on) begin
      elapsed = '0;
    end else begin
      elapsed = 64'(c) - 64'(m_on) - 64'd1;
    end
    d = ((elapsed * 64'd10) / 64'd292) / 64'd2;
    if (d <= 64'(m_offset)) begin
      return '0;
    end
    d = d - 64'(m_offset);
    if (d > 64'd65535) begin
      d = 64'd65535;
    end
    return d[DIST_W-1:0];
  endfunction

  function automatic ranger_result_t next_ranger_result(input logic cmd, input logic echo);
    ranger_result_t r;
    logic [COUNT_W-1:0] c;
    r = '0;
    if (cmd == CMD_TICK) begin
      c = m_ticks;
      if (c == m_on) begin
        m_trig = 1'b1;
      end
      if (c == m_off) begin
        m_trig = 1'b0;
      end
      if (m_echo_q && !echo) begin
        r.measured = 1'b1;
        r.distance_cm = echo_to_cm(c);
        m_dist_mem[m_wr_ptr] = r.distance_cm;
        m_wr_ptr = (m_wr_ptr + 1) % FIFO_DEPTH;
        if (m_fill == FIFO_DEPTH) begin
          m_rd_ptr = (m_rd_ptr + 1) % FIFO_DEPTH;
          n_overwrites++;
        end else begin
          m_fill++;
        end
        m_ticks = '0;
        n_meas++;
      end else begin
        m_ticks = c + 1'b1;
      end
      m_echo_q = echo;
    end else begin
      n_pops++;
      if (m_fill != 0) begin
        r.pop_valid = 1'b1;
        r.pop_data = m_dist_mem[m_rd_ptr];
        m_rd_ptr = (m_rd_ptr + 1) % FIFO_DEPTH;
        m_fill--;
      end else begin
        n_empty_pops++;
      end
    end
    r.trigger_level = m_trig;
    return r;
  endfunction

  task automatic send_item(input logic c, input logic e, input logic typed = 1'b0,
                           input ranger_result_t want = '0);
    ranger_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= c;
    item_ch.echo_level <= e;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    predicted = next_ranger_result(c, e);
    ranger_results_q.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_TRIGGER_ON: begin
        m_on = val;
      end
      CFG_TRIGGER_OFF: begin
        m_off = val;
      end
      CFG_OFFSET: begin
        m_offset = val[OFFSET_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_ranger(input logic [COUNT_W-1:0] on, input logic [COUNT_W-1:0] off,
                            input logic [OFFSET_W-1:0] ofs);
    write_reg(CFG_TRIGGER_ON, on);
    write_reg(CFG_TRIGGER_OFF, off);
    write_reg(CFG_OFFSET, {24'($urandom), ofs});
    write_reg(CFG_UNUSED, $urandom);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (ranger_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // complete echo pulses with pops mixed in, plus stand-alone pops (pop_pct percent) and echo noise
  task automatic run_phase(input logic [COUNT_W-1:0] on, input logic [COUNT_W-1:0] off,
                           input logic [OFFSET_W-1:0] ofs, input int pop_pct,
                           input bit gaps, input bit hold);
    int start;
    int pre;
    int len;
    int r;
    set_ranger(on, off, ofs);
    gaps_on = gaps;
    hold_req = hold;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        send_item(CMD_POP, 1'($urandom_range(0, 1)));
      end else if (r < pop_pct + 15) begin
        send_item(CMD_TICK, 1'($urandom_range(0, 1)));
      end else begin
        pre = $urandom_range(0, 6);
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 700) : $urandom_range(1, 12);
        repeat (pre) send_item(CMD_TICK, 1'b0);
        repeat (len) begin
          if ($urandom_range(0, 99) < pop_pct / 4) begin
            send_item(CMD_POP, 1'($urandom_range(0, 1)));
          end
          send_item(CMD_TICK, 1'b1);
        end
        send_item(CMD_TICK, 1'b0);
      end
    end
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_TICK;
    item_ch.echo_level = 1'b0;
    m_on               = TRIGGER_ON_RESET;
    m_off              = TRIGGER_OFF_RESET;
    m_offset           = OFFSET_RESET;
    m_ticks            = '0;
    m_trig             = 1'b0;
    m_echo_q           = 1'b0;
    m_wr_ptr           = 0;
    m_rd_ptr           = 0;
    m_fill             = 0;
    n_errors           = 0;
    items_sent         = 0;
    n_meas             = 0;
    n_pops             = 0;
    n_empty_pops       = 0;
    n_overwrites       = 0;
    n_settings         = 0;
    burst_left         = 0;
    gaps_on            = 1'b1;
    hold_req           = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 12; i++) begin
      repeat (DIR_ROWS[i].reps) begin
        send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].echo, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end
    drain();

    // one long echo with the trigger raised at count 0
    set_ranger('0, 32'd4, '0);
    gaps_on = 1'b0;
    repeat (LONG_ECHO) send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_POP, 1'b0);
    drain();

    run_phase(TRIGGER_ON_RESET, TRIGGER_OFF_RESET, OFFSET_RESET, 20, 1'b0, 1'b1);
    run_phase('0, '0, '0, 15, 1'b1, 1'b0);
    run_phase(32'd5, 32'd5, 8'd255, 25, 1'b0, 1'b0);
    run_phase('1, '1, '0, 20, 1'b1, 1'b0);
    run_phase('0, '1, 8'd1, 3, 1'b1, 1'b0);
    run_phase(32'd2, 32'd1, '0, 80, 1'b1, 1'b0);
    run_phase($urandom_range(0, 20), $urandom_range(0, 40), $urandom_range(0, 255),
              20, 1'b1, 1'b0);
    run_phase($urandom, $urandom, $urandom_range(0, 255), 20, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    $display("Sent %0d items: %0d echo measurements, %0d overwrites of a full buffer,",
             items_sent, n_meas, n_overwrites);
    $display("%0d pops (%0d on an empty buffer) across %0d register settings.",
             n_pops, n_empty_pops, n_settings);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    hold_left     = 0;
    stall_pattern = 0;
    stall_stretch = 0;
    stall_phase   = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else begin
        if (stall_stretch == 0) begin
          stall_pattern = $urandom_range(0, 3);
          stall_stretch = $urandom_range(20, 200);
        end
        stall_stretch--;
        stall_phase++;
        case (stall_pattern)
          0: begin
            result_ch.ready <= 1'b1;
          end
          1: begin
            result_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            result_ch.ready <= ($urandom_range(0, 6) != 0);
          end
          default: begin
            result_ch.ready <= (stall_phase % 3 == 0);
          end
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (ranger_results_q.size() == 0) begin
        $error("result transfer with no result pending");
        n_errors++;
      end else begin
        result_seen = ranger_results_q.pop_front();
        check_field("trigger_level", result_seen.trigger_level, result_ch.trigger_level);
        check_field("measured", result_seen.measured, result_ch.measured);
        check_field("distance_cm", result_seen.distance_cm, result_ch.distance_cm);
        check_field("pop_valid", result_seen.pop_valid, result_ch.pop_valid);
        check_field("pop_data", result_seen.pop_data, result_ch.pop_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### ultrasonic_echo_ranger_fifo.f
rtl/uer_pkg.sv
rtl/uer_if.sv
rtl/uer_convert.sv
rtl/ultrasonic_echo_ranger_fifo.sv
tb/tb.sv
